>>> src/frame_checker_channel_averager_top_assert.svh
`ifndef FRAME_CHECKER_CHANNEL_AVERAGER_TOP_ASSERT_SVH
`define FRAME_CHECKER_CHANNEL_AVERAGER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FCCA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define FCCA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/fcca_pkg.sv
package fcca_pkg;

	localparam int WORD_W   = 24;
	localparam int DATA_W   = 16;
	localparam int AVG_W    = 32;
	localparam int GAIN_W   = 16;

	localparam int FRAME_WORDS_DEF = 18;
	localparam int CHANNELS_DEF    = 4;
	localparam int OUT_FIELDS      = 4;

	localparam logic [WORD_W-1:0] START_WORD = 24'hAAAAAA;
	localparam logic [WORD_W-1:0] END_WORD   = 24'hAAFFFF;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd66;

	// per-lane control from the frame decision
	typedef struct packed {
		logic adv;    // pipeline may move
		logic start;  // frame accepted, this lane updates
	} lane_ctrl_t;

endpackage

>>> src/fcca_hist_cell.sv
module fcca_hist_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       shift,
	input  logic [fcca_pkg::WORD_W-1:0] d,
	output logic [fcca_pkg::WORD_W-1:0] q
);
	import fcca_pkg::*;

	logic [WORD_W-1:0] word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

>>> src/fcca_ema_lane.sv
module fcca_ema_lane (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fcca_pkg::lane_ctrl_t        ctrl,
	input  logic [fcca_pkg::DATA_W-1:0] x,
	input  logic [fcca_pkg::GAIN_W-1:0] alpha,
	output logic [fcca_pkg::AVG_W-1:0]  avg
);
	import fcca_pkg::*;

	localparam int DIFF_W = AVG_W + 2;
	localparam int PROD_W = DIFF_W + GAIN_W + 1;
	localparam int SUM_W  = PROD_W - 16;

	logic [AVG_W-1:0]         avg_q;
	logic                     v_s1;
	logic                     v_s2;
	logic signed [DIFF_W-1:0] diff_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [DIFF_W-1:0] diff_d;
	logic signed [PROD_W-1:0] prod_d;
	logic [SUM_W-1:0]         sum_d;

	// target minus average, exact
	assign diff_d = $signed({2'b00, x, 16'h0000}) - $signed({2'b00, avg_q});
	assign prod_d = diff_s1 * $signed({1'b0, alpha});
	// arithmetic shift floors toward minus infinity
	assign sum_d  = {{(SUM_W-AVG_W){1'b0}}, avg_q} + prod_s2[PROD_W-1:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			avg_q <= '0;
		end else if (ctrl.adv) begin
			v_s1 <= ctrl.start;
			v_s2 <= v_s1;
			if (v_s2) begin
				avg_q <= sum_d[AVG_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			diff_s1 <= diff_d;
			prod_s2 <= prod_d;
		end
	end

	assign avg = avg_q;

endmodule

>>> src/frame_checker_channel_averager_top.sv
// channel | handshake                   | payload
// --------+-----------------------------+---------------------------------
// input   | in_valid / in_stall         | word (24 bits)
// output  | out_valid / out_stall       | average_ch0 .. average_ch3 (Q16.16)
// config  | cfg_valid / cfg_ready       | cfg_data (smoothing gain, Q0.16)
//
// one word per cycle while in_stall is low; the frame decision is made on the cycle the end word arrives
// a valid frame shows its averages after the diff, product and add registers; hold freezes them
// arst_n clears history, blocked count, averages and valid bits; gain resets to 66
// in_stall rises only while a result sits stalled at the output and another frame is
// still in the update pipeline; otherwise words flow regardless of out_stall
module frame_checker_channel_averager_top #(
	parameter int FRAME_WORDS = fcca_pkg::FRAME_WORDS_DEF,
	parameter int CHANNELS    = fcca_pkg::CHANNELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [fcca_pkg::WORD_W-1:0] word,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [fcca_pkg::AVG_W-1:0]  average_ch0,
	output logic [fcca_pkg::AVG_W-1:0]  average_ch1,
	output logic [fcca_pkg::AVG_W-1:0]  average_ch2,
	output logic [fcca_pkg::AVG_W-1:0]  average_ch3,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [fcca_pkg::GAIN_W-1:0] cfg_data
);
	import fcca_pkg::*;

	localparam int HIST  = FRAME_WORDS - 1;
	localparam int BLK_W = $clog2(FRAME_WORDS + 1);

	logic [WORD_W-1:0] hist [HIST];
	logic [AVG_W-1:0]  avg  [CHANNELS];
	logic [AVG_W-1:0]  out_avg [OUT_FIELDS];
	logic [DATA_W-1:0] ch_x [CHANNELS];
	lane_ctrl_t        lane_ctrl [CHANNELS];

	logic [GAIN_W-1:0] gain_q;
	logic [BLK_W-1:0]  blocked_q;
	logic              frame_v_s1;
	logic              frame_v_s2;
	logic              out_valid_q;
	logic              hold;
	logic              accept;
	logic              frame_hit;
	logic              frame_go;

	// config register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			gain_q <= cfg_data;
		end
	end

	// freeze the update pipeline when a result waits and another frame follows
	assign hold     = out_valid_q && out_stall && (frame_v_s1 || frame_v_s2);
	assign in_stall = hold;
	assign accept   = in_valid && !in_stall;

	// word history: chain of cells, newest in cell 0, oldest is the start candidate
	for (genvar i = 0; i < HIST; i++) begin : g_hist
		if (i == 0) begin : g_head
			fcca_hist_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (accept),
				.d      (word),
				.q      (hist[i])
			);
		end else begin : g_body
			fcca_hist_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (accept),
				.d      (hist[i-1]),
				.q      (hist[i])
			);
		end
	end

	// start word at the oldest position, end word arriving now, not blocked
	assign frame_hit = (blocked_q == '0) && (hist[HIST-1] == START_WORD) && (word == END_WORD);
	assign frame_go  = accept && frame_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocked_q   <= '0;
			frame_v_s1  <= 1'b0;
			frame_v_s2  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (blocked_q != '0) begin
					blocked_q <= blocked_q - 1'b1;
				end else if (frame_hit) begin
					blocked_q <= BLK_W'(FRAME_WORDS);
				end
			end
			if (!hold) begin
				frame_v_s1 <= frame_go;
				frame_v_s2 <= frame_v_s1;
			end
			// averages register doubles as the output register
			if (!hold && frame_v_s2) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// channel lanes; channel i reads the word right after start plus i
	for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
		localparam int K = HIST - 2 - i;
		if (K >= 0) begin : g_hist_src
			assign ch_x[i]            = hist[K][DATA_W-1:0];
			assign lane_ctrl[i].start = frame_go;
		end else if (K == -1) begin : g_end_src
			// channel word coincides with the end word
			assign ch_x[i]            = word[DATA_W-1:0];
			assign lane_ctrl[i].start = frame_go;
		end else begin : g_no_src
			// channel word lies past the end word, average never moves
			assign ch_x[i]            = '0;
			assign lane_ctrl[i].start = 1'b0;
		end
		assign lane_ctrl[i].adv = !hold;

		fcca_ema_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (lane_ctrl[i]),
			.x      (ch_x[i]),
			.alpha  (gain_q),
			.avg    (avg[i])
		);
	end

	// output fields, missing channels read as zero
	for (genvar j = 0; j < OUT_FIELDS; j++) begin : g_out
		if (j < CHANNELS) begin : g_ch
			assign out_avg[j] = avg[j];
		end else begin : g_zero
			assign out_avg[j] = '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign average_ch0 = out_avg[0];
	assign average_ch1 = out_avg[1];
	assign average_ch2 = out_avg[2];
	assign average_ch3 = out_avg[3];

	`include "frame_checker_channel_averager_top_assert.svh"

	`FCCA_ASSERT_NEXT(a_frame_blocks, frame_go, blocked_q == BLK_W'(FRAME_WORDS), "frame did not load the blocked count")
	`FCCA_ASSERT_NOW(a_pipe_blocked, frame_v_s1 || frame_v_s2, blocked_q != '0, "frame in update pipeline while starts unblocked")
	`FCCA_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a waiting result")
	`FCCA_ASSERT_NEXT(a_result_shown, frame_v_s2 && !hold, out_valid, "finished frame not presented")

endmodule

>>> tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fcca_pkg::*;

	// history holds the words before the current one, newest at index 0
	localparam int HIST_DEPTH     = FRAME_WORDS_DEF - 1;
	// results show once the end word has passed the update pipeline; this margin covers it
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 5000;
	// long output hold-off to back the block up into its input
	localparam int HOLD_CYCLES    = 250;
	localparam int HOLD_AT_WORD   = 300;
	// window of accepted words with no random idling on either side
	localparam int CALM_FROM      = 600;
	localparam int CALM_TO        = 900;
	localparam int PHASE_WORDS    = 185;
	localparam int MAX_REPORTS    = 10;

	typedef logic [OUT_FIELDS-1:0][AVG_W-1:0] avg_set_t;

	// kinds of word runs the random stimulus is built from
	typedef enum int {
		CHUNK_GOOD,
		CHUNK_BAD_END,
		CHUNK_BAD_START,
		CHUNK_NOISE,
		CHUNK_CUT
	} chunk_kind_t;

	// tracks the frame search and the channel averages, holds expected results
	class frame_average_tracker;
		logic [WORD_W-1:0] history [HIST_DEPTH];
		int unsigned       blocked;
		logic [AVG_W-1:0]  averages [CHANNELS_DEF];
		logic [GAIN_W-1:0] gain;
		avg_set_t          expected_averages [$];
		int unsigned       words_taken;
		int unsigned       mismatches;

		function new();
			foreach (history[i]) history[i] = '0;
			foreach (averages[i]) averages[i] = '0;
			blocked     = 0;
			gain        = GAIN_RESET;
			words_taken = 0;
			mismatches  = 0;
		endfunction

		function void set_gain(logic [GAIN_W-1:0] g);
			gain = g;
		endfunction

		function int pending();
			return expected_averages.size();
		endfunction

		// avg += alpha*(x - avg), product floored
		function logic [AVG_W-1:0] smooth(logic [AVG_W-1:0] avg, logic [DATA_W-1:0] x);
			logic [63:0] target;
			logic [63:0] cur;
			logic [63:0] prod;
			logic [63:0] step;
			target = {32'd0, x, 16'd0};
			cur    = {32'd0, avg};
			if (target >= cur) begin
				prod = (target - cur) * {48'd0, gain};
				step = prod >> 16;
				return avg + step[AVG_W-1:0];
			end else begin
				prod = (cur - target) * {48'd0, gain};
				step = (prod + 64'h0000_0000_0000_FFFF) >> 16;
				return avg - step[AVG_W-1:0];
			end
		endfunction

		function void absorb_word(logic [WORD_W-1:0] w);
			avg_set_t result;
			bit       frame_ok;
			int       k;
			frame_ok = 1'b0;
			words_taken++;
			if (blocked > 0) begin
				blocked--;
			end else if (history[HIST_DEPTH-1] == START_WORD && w == END_WORD) begin
				frame_ok = 1'b1;
				blocked  = FRAME_WORDS_DEF;
			end
			if (frame_ok) begin
				for (int i = 0; i < CHANNELS_DEF; i++) begin
					k = HIST_DEPTH - 2 - i;
					if (k >= 0)
						averages[i] = smooth(averages[i], history[k][DATA_W-1:0]);
					else if (k == -1)
						averages[i] = smooth(averages[i], w[DATA_W-1:0]);
				end
			end
			for (int i = HIST_DEPTH - 1; i > 0; i--)
				history[i] = history[i-1];
			history[0] = w;
			if (frame_ok) begin
				result = '0;
				for (int i = 0; i < CHANNELS_DEF && i < OUT_FIELDS; i++)
					result[i] = averages[i];
				expected_averages.push_back(result);
			end
		endfunction

		function void check_averages(avg_set_t got);
			avg_set_t              want;
			logic [OUT_FIELDS-1:0] wrong;
			if (expected_averages.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result with nothing expected: ch0..3 %h %h %h %h",
						$realtime, got[0], got[1], got[2], got[3]);
				return;
			end
			want = expected_averages.pop_front();
			for (int i = 0; i < OUT_FIELDS; i++)
				wrong[i] = (got[i] !== want[i]);
			if (wrong != '0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: average mismatch, channels %b: exp %h %h %h %h got %h %h %h %h",
						$realtime, wrong, want[0], want[1], want[2], want[3],
						got[0], got[1], got[2], got[3]);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [WORD_W-1:0]   word;
	logic                out_valid;
	logic                out_stall;
	logic [AVG_W-1:0]    average_ch0;
	logic [AVG_W-1:0]    average_ch1;
	logic [AVG_W-1:0]    average_ch2;
	logic [AVG_W-1:0]    average_ch3;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [GAIN_W-1:0]   cfg_data;

	frame_average_tracker board;
	int unsigned          idle_cycles = 0;

	frame_checker_channel_averager_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.word        (word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.average_ch0 (average_ch0),
		.average_ch1 (average_ch1),
		.average_ch2 (average_ch2),
		.average_ch3 (average_ch3),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	// 4 ns clock
	always #2 clk = ~clk;

	// no random idling on either side inside this window
	function automatic bit calm();
		return board.words_taken >= CALM_FROM && board.words_taken < CALM_TO;
	endfunction

	// random word, low 16 bits sometimes forced to an extreme, sometimes a marker word
	function automatic logic [WORD_W-1:0] body_word();
		logic [WORD_W-1:0] w;
		w = WORD_W'($urandom);
		case ($urandom_range(0, 15))
			0: w[DATA_W-1:0] = '0;
			1: w[DATA_W-1:0] = '1;
			2: w = START_WORD;
			3: w = END_WORD;
			default: ;
		endcase
		return w;
	endfunction

	// all transactions are seen at the rising edge; output first, then input, then config
	always @(posedge clk) begin
		if (arst_n) begin
			idle_cycles++;
			if (out_valid && !out_stall) begin
				board.check_averages({average_ch3, average_ch2, average_ch1, average_ch0});
				idle_cycles = 0;
			end
			if (in_valid && !in_stall) begin
				board.absorb_word(word);
				idle_cycles = 0;
			end
			if (cfg_valid && cfg_ready) begin
				board.set_gain(cfg_data);
				idle_cycles = 0;
			end
			// watchdog: nothing moved for too long
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// output side: random stall, one long hold-off, calm window
	initial begin : sink
		bit held;
		held      = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && board.words_taken >= HOLD_AT_WORD) begin
				// hold the output while the sender keeps offering words
				held      = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				out_stall <= !calm() && ($urandom_range(0, 99) < 7);
			end
		end
	end

	// offer one word and hold it until taken; called and returns at a falling edge
	task automatic push_word(input logic [WORD_W-1:0] w);
		while (!calm() && $urandom_range(0, 99) < 7) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		word     <= w;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// start word, frame body, word in the end position
	task automatic push_frame(input logic [WORD_W-1:0] first, input logic [WORD_W-1:0] last);
		push_word(first);
		repeat (FRAME_WORDS_DEF - 2) push_word(body_word());
		push_word(last);
	endtask

	task automatic push_chunk();
		chunk_kind_t kind;
		int          r;
		r = $urandom_range(0, 99);
		if (r < 55)
			kind = CHUNK_GOOD;
		else if (r < 68)
			kind = CHUNK_BAD_END;
		else if (r < 80)
			kind = CHUNK_BAD_START;
		else if (r < 92)
			kind = CHUNK_NOISE;
		else
			kind = CHUNK_CUT;
		case (kind)
			CHUNK_GOOD: begin
				// short gap so the next start often lands in the blocked window
				push_frame(START_WORD, END_WORD);
				repeat ($urandom_range(0, 3)) push_word(body_word());
			end
			CHUNK_BAD_END:
				push_frame(START_WORD, END_WORD ^ (WORD_W'(1) << $urandom_range(0, WORD_W - 1)));
			CHUNK_BAD_START:
				push_frame(START_WORD ^ (WORD_W'(1) << $urandom_range(0, WORD_W - 1)), END_WORD);
			CHUNK_NOISE:
				repeat ($urandom_range(1, 20)) push_word(body_word());
			CHUNK_CUT: begin
				// start word with a frame that breaks off early
				push_word(START_WORD);
				repeat ($urandom_range(0, FRAME_WORDS_DEF - 3)) push_word(body_word());
			end
			default: ;
		endcase
	endtask

	// gain is only written with the block idle
	task automatic write_gain(input logic [GAIN_W-1:0] g);
		cfg_valid <= 1'b1;
		cfg_data  <= g;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait out every expected result plus the pipeline depth
	task automatic drain();
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin : stimulus
		logic [GAIN_W-1:0] gains [5];
		int unsigned       phase_start;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		word      = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		board     = new();
		gains     = '{16'hFFFF, 16'h0000, 16'h0001, 16'h8000, 16'h0000};
		gains[4]  = GAIN_W'($urandom_range(0, 65535));
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// end word on a zero history after reset: no frame
		push_word(END_WORD);
		// frame with extreme channel words under the reset gain
		push_word(START_WORD);
		push_word(24'hFFFFFF);
		push_word(24'h000000);
		push_word(24'hFF0000);
		push_word(24'h00FFFF);
		repeat (FRAME_WORDS_DEF - 6) push_word(body_word());
		push_word(END_WORD);
		// start right after a valid frame is blocked
		push_word(START_WORD);

		// first phase keeps the reset gain, later ones walk the gain list
		for (int phase = 0; phase <= 5; phase++) begin
			if (phase > 0) begin
				in_valid <= 1'b0;
				drain();
				write_gain(gains[phase-1]);
			end
			phase_start = board.words_taken;
			while (board.words_taken - phase_start < PHASE_WORDS)
				push_chunk();
		end

		in_valid <= 1'b0;
		drain();
		if (board.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
